// ===== hw/rtl/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared constants and types of the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppm_pkg;

	localparam int MAX_CHANNELS_DEF = 16;

	// Field widths
	localparam int CNT_W     = 6;   // holds a channel count up to 63
	localparam int CHAN_W    = 5;
	localparam int VAL_W     = 16;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	// Reset values and substitutes for a zero register
	localparam int unsigned DEF_CHANNEL_COUNT  = 8;
	localparam int unsigned DEF_SYNC_WIDTH     = 3000;
	localparam int unsigned DEF_SIGNAL_TIMEOUT = 100000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT  = 2'd0,
		REG_SYNC_WIDTH     = 2'd1,
		REG_SIGNAL_TIMEOUT = 2'd2
	} cfg_reg_t;

	// Effective configuration seen by the datapath
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [VAL_W-1:0]  sync;
		logic [TIME_W-1:0] timeout;
	} cfg_t;

	// Slot write from the frame tracker to the channel store
	typedef struct packed {
		logic             we;
		logic [CNT_W-1:0] idx;
		logic [VAL_W-1:0] data;
	} slot_wr_t;

endpackage

// ===== hw/rtl/ppm_if.sv =====
// ----------------------------------------------------------------------------
// ppm_tick_if / ppm_result_if
// Valid/ready channels carrying one tick item and one result item.
// ----------------------------------------------------------------------------
interface ppm_tick_if;
	logic        valid;
	logic        ready;
	logic        edge_req;
	logic        snapshot;
	logic [4:0]  read_channel;
	logic [15:0] default_value;

	modport source (output valid, edge_req, snapshot, read_channel, default_value,
		input ready);
	modport sink (input valid, edge_req, snapshot, read_channel, default_value,
		output ready);
	modport monitor (input valid, ready, edge_req, snapshot, read_channel,
		default_value);
endinterface

interface ppm_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_value;
	logic [15:0] valid_value;
	logic [31:0] frame_age;
	logic        signal_valid;

	modport source (output valid, raw_value, valid_value, frame_age, signal_valid,
		input ready);
	modport sink (input valid, raw_value, valid_value, frame_age, signal_valid,
		output ready);
	modport monitor (input valid, ready, raw_value, valid_value, frame_age,
		signal_valid);
endinterface

// ===== hw/rtl/ppm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ppm_cfg_regs
// Configuration registers and their effective values.
// ----------------------------------------------------------------------------
module ppm_cfg_regs import ppm_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	localparam int DEF_CNT = (DEF_CHANNEL_COUNT > MAX_CHANNELS) ?
		MAX_CHANNELS : DEF_CHANNEL_COUNT;

	logic [CHAN_W-1:0] count_q;
	logic [VAL_W-1:0]  sync_q;
	logic [TIME_W-1:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= CHAN_W'(DEF_CHANNEL_COUNT);
			sync_q    <= VAL_W'(DEF_SYNC_WIDTH);
			timeout_q <= TIME_W'(DEF_SIGNAL_TIMEOUT);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CHANNEL_COUNT:  count_q   <= cfg_data[CHAN_W-1:0];
				REG_SYNC_WIDTH:     sync_q    <= cfg_data[VAL_W-1:0];
				REG_SIGNAL_TIMEOUT: timeout_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero count means the default; clamp anything above the slot count
	always_comb begin
		if (count_q == '0) begin
			cfg.count = CNT_W'(DEF_CNT);
		end else if ({1'b0, count_q} > CNT_W'(MAX_CHANNELS)) begin
			cfg.count = CNT_W'(MAX_CHANNELS);
		end else begin
			cfg.count = {1'b0, count_q};
		end
		cfg.sync    = (sync_q == '0) ? VAL_W'(DEF_SYNC_WIDTH) : sync_q;
		cfg.timeout = timeout_q;
	end

endmodule

// ===== hw/rtl/ppm_frame_track.sv =====
// ----------------------------------------------------------------------------
// ppm_frame_track
// Tick counter, edge gap measurement, sync detection and frame age.
// ----------------------------------------------------------------------------
module ppm_frame_track import ppm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              edge_req,
	input  cfg_t              cfg,
	output slot_wr_t          slot_wr,
	output logic [TIME_W-1:0] age
);

	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] last_edge_q;
	logic [TIME_W-1:0] last_frame_q;
	logic [CNT_W-1:0]  chan_idx_q;
	logic              frame_seen_q;

	logic [TIME_W-1:0] gap;
	logic              is_sync;
	logic              frame_done;

	assign gap        = time_q - last_edge_q;
	assign is_sync    = gap >= {{(TIME_W-VAL_W){1'b0}}, cfg.sync};
	assign frame_done = edge_req && is_sync && (chan_idx_q != '0);

	always_comb begin
		slot_wr.we   = edge_req && !is_sync && (chan_idx_q < cfg.count);
		slot_wr.idx  = chan_idx_q;
		slot_wr.data = (gap[TIME_W-1:VAL_W] != '0) ? '1 : gap[VAL_W-1:0];
	end

	// Age reflects a frame closed by this very tick
	always_comb begin
		if (frame_done) begin
			age = '0;
		end else if (frame_seen_q) begin
			age = time_q - last_frame_q;
		end else begin
			age = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q       <= '0;
			last_edge_q  <= '0;
			last_frame_q <= '0;
			chan_idx_q   <= '0;
			frame_seen_q <= 1'b0;
		end else if (step) begin
			time_q <= time_q + TIME_W'(1);
			if (edge_req) begin
				last_edge_q <= time_q;
				if (is_sync) begin
					chan_idx_q <= '0;
				end else if (slot_wr.we) begin
					chan_idx_q <= chan_idx_q + CNT_W'(1);
				end
			end
			if (frame_done) begin
				last_frame_q <= time_q;
				frame_seen_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ppm_chan_store.sv =====
// ----------------------------------------------------------------------------
// ppm_chan_store
// Live and held channel slots, snapshot copy and channel read.
// ----------------------------------------------------------------------------
module ppm_chan_store import ppm_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  slot_wr_t          slot_wr,
	input  logic              snapshot,
	input  logic [CHAN_W-1:0] read_channel,
	input  logic [CNT_W-1:0]  count,
	output logic [VAL_W-1:0]  raw
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [VAL_W-1:0] live_q [MAX_CHANNELS];
	logic [VAL_W-1:0] held_q [MAX_CHANNELS];
	logic [VAL_W-1:0] live_nxt [MAX_CHANNELS];

	logic             rd_ok;
	logic [CNT_W-1:0] rd_idx;

	always_comb begin
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			if (slot_wr.we && (slot_wr.idx[IDX_W-1:0] == IDX_W'(i))) begin
				live_nxt[i] = slot_wr.data;
			end else begin
				live_nxt[i] = live_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				live_q[i] <= '0;
				held_q[i] <= '0;
			end
		end else if (step) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				live_q[i] <= live_nxt[i];
				if (snapshot && (CNT_W'(i) < count)) begin
					held_q[i] <= live_nxt[i];
				end
			end
		end
	end

	// A snapshot in the same tick is visible to the read
	assign rd_ok  = (read_channel != '0) && ({1'b0, read_channel} <= count);
	assign rd_idx = {1'b0, read_channel} - CNT_W'(1);

	always_comb begin
		if (!rd_ok) begin
			raw = '0;
		end else if (snapshot) begin
			raw = live_nxt[rd_idx[IDX_W-1:0]];
		end else begin
			raw = held_q[rd_idx[IDX_W-1:0]];
		end
	end

endmodule

// ===== hw/rtl/ppm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// Pulse-position RC frame decoder, one microsecond tick per item.
// ----------------------------------------------------------------------------
// Each tick transfer advances a 32-bit wrapping time counter and yields
// exactly one result transfer. An item is taken into an input register,
// worked on combinationally (gap measurement, slot update, snapshot, read
// and frame age) and lands in a result register, so a new tick is accepted
// on every clock while the result side keeps pace. Back-pressure on the
// result channel holds the result register and then the input register.
// Within a tick the edge is handled first, then the snapshot, then the read,
// so a read sees a slot written and copied in the same tick. Configuration
// is written through cfg_we/cfg_index/cfg_data; the user must write it while
// no tick is in flight, as the block itself does not enforce this.
module ppm_frame_decoder import ppm_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ppm_tick_if.sink             tick,
	ppm_result_if.source         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t     cfg;
	slot_wr_t slot_wr;

	// Input register
	logic              v_s1;
	logic              edge_s1;
	logic              snap_s1;
	logic [CHAN_W-1:0] rd_ch_s1;
	logic [VAL_W-1:0]  defv_s1;

	// Result register
	logic              v_s2;
	logic [VAL_W-1:0]  raw_s2;
	logic [VAL_W-1:0]  valv_s2;
	logic [TIME_W-1:0] age_s2;
	logic              sig_s2;

	logic              step;
	logic [VAL_W-1:0]  raw;
	logic [TIME_W-1:0] age;

	// Advance the held tick whenever the result register is free or draining
	assign step       = v_s1 && (!v_s2 || result.ready);
	assign tick.ready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tick.ready) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			edge_s1  <= tick.edge_req;
			snap_s1  <= tick.snapshot;
			rd_ch_s1 <= tick.read_channel;
			defv_s1  <= tick.default_value;
		end
	end

	ppm_cfg_regs #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	ppm_frame_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.edge_req(edge_s1),
		.cfg     (cfg),
		.slot_wr (slot_wr),
		.age     (age)
	);

	ppm_chan_store #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.slot_wr     (slot_wr),
		.snapshot    (snap_s1),
		.read_channel(rd_ch_s1),
		.count       (cfg.count),
		.raw         (raw)
	);

	// Hold the result until it is taken; a fresh one may replace it in the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (step) begin
			v_s2 <= 1'b1;
		end else if (result.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			raw_s2  <= raw;
			valv_s2 <= (raw == '0) ? defv_s1 : raw;
			age_s2  <= age;
			sig_s2  <= (age <= cfg.timeout);
		end
	end

	assign result.valid        = v_s2;
	assign result.raw_value    = raw_s2;
	assign result.valid_value  = valv_s2;
	assign result.frame_age    = age_s2;
	assign result.signal_valid = sig_s2;

endmodule

// ===== hw/rtl/ppm_checker.sv =====
// ----------------------------------------------------------------------------
// ppm_checker
// Port-level checks of the PPM frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ppm_checker import ppm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [VAL_W-1:0]     raw_value,
	input logic [VAL_W-1:0]     valid_value,
	input logic [TIME_W-1:0]    frame_age,
	input logic                 signal_valid,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DAT_W-1:0] cfg_data
);

	logic [TIME_W-1:0] timeout_q;

	// Track the timeout register from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIME_W'(DEF_SIGNAL_TIMEOUT);
		end else if (cfg_we && (cfg_index == REG_SIGNAL_TIMEOUT)) begin
			timeout_q <= cfg_data[TIME_W-1:0];
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped before transfer");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			$stable(raw_value) && $stable(valid_value) &&
			$stable(frame_age) && $stable(signal_valid))
		else $error("stalled result payload changed");

	a_default_subst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (raw_value != '0) |-> valid_value == raw_value)
		else $error("non-zero raw value replaced by default");

	a_signal_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> signal_valid == (frame_age <= timeout_q))
		else $error("signal_valid disagrees with frame age and timeout");

endmodule

bind ppm_frame_decoder ppm_checker u_ppm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.raw_value   (result.raw_value),
	.valid_value (result.valid_value),
	.frame_age   (result.frame_age),
	.signal_valid(result.signal_valid),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.cfg_data    (cfg_data)
);
